/* src/cwpc_pkg.sv */
// Shared types, sizes and codes for the cycle witness parity checker.
// Depends on nothing; every other file of the block depends on it.
`default_nettype none

package cwpc_pkg;

    // Store sizes and field widths
    localparam int MAX_VERTICES = 1024;
    localparam int MAX_EDGES    = 2048;
    localparam int SUPPORT_SIZE = 4;
    localparam int VW           = $clog2(MAX_VERTICES);
    localparam int EW           = $clog2(MAX_EDGES);
    localparam int SLW          = $clog2(SUPPORT_SIZE);
    localparam int VCW          = VW + 1;
    localparam int ECW          = EW + 1;
    localparam int CW           = EW + 1;
    localparam int CFG_DW       = 12;
    localparam int CMDW         = 2;
    localparam int RESW         = 3;

    typedef enum logic [CMDW-1:0] {
        CMD_EDGE  = 2'd0,
        CMD_WIT   = 2'd1,
        CMD_SUP   = 2'd2,
        CMD_CHECK = 2'd3
    } cmd_t;

    typedef enum logic [RESW-1:0] {
        RES_OK        = 3'd0,
        RES_SUP_RANGE = 3'd1,
        RES_SUP_MATCH = 3'd2,
        RES_WIT_SUP   = 3'd3,
        RES_BAD_DEG   = 3'd4,
        RES_ODD_COMP  = 3'd5
    } res_t;

    typedef enum logic {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_EDGE_COUNT   = 1'b1
    } cfg_idx_t;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR,
        S_SUP_A, S_SUP_B, S_SUP_C, S_SUP_D,
        S_EDG_A, S_EDG_B, S_EDG_C, S_EDG_D,
        S_DEG_A, S_DEG_B,
        S_WLK_A, S_WLK_B,
        S_Q_A, S_Q_B, S_Q_C,
        S_N_RD, S_N_CHK,
        S_FIN
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_CLR,
        OP_SUP_A, OP_SUP_B, OP_SUP_C, OP_SUP_D,
        OP_EDG_A, OP_EDG_B, OP_EDG_C, OP_EDG_D,
        OP_DEG_A, OP_DEG_B,
        OP_WLK_A, OP_WLK_B,
        OP_Q_A, OP_Q_B, OP_Q_C,
        OP_N_RD, OP_N_CHK
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic cnt_end;
        logic sup_oor;
        logic term_hit;
        logic wit_sel;
        logic edge_sel;
        logic edge_oob;
        logic deg_bad;
        logic skip;
        logic q_empty;
        logic parity;
        logic has_nb;
        logic more_nb;
    } dp_stat_t;

    // Two-bit degree counter that sticks at three
    function automatic logic [1:0] sat_inc(input logic [1:0] d);
        logic [1:0] r;
        r = (d == 2'd3) ? 2'd3 : d + 2'd1;
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/cwpc_item_if.sv */
// Channel interfaces for input items and result items.
// Depends on cwpc_pkg for field widths.
`default_nettype none

interface cwpc_item_if;
    logic                        valid;
    logic                        ready;
    logic [cwpc_pkg::CMDW-1:0]   cmd;
    logic [cwpc_pkg::EW-1:0]     edge_index;
    logic [cwpc_pkg::VW-1:0]     end_a;
    logic [cwpc_pkg::VW-1:0]     end_b;
    logic                        in_cycle;
    logic [cwpc_pkg::SLW-1:0]    support_slot;

    modport source (output valid, cmd, edge_index, end_a, end_b, in_cycle, support_slot,
                    input ready);
    modport sink   (input valid, cmd, edge_index, end_a, end_b, in_cycle, support_slot,
                    output ready);
endinterface

interface cwpc_result_if;
    logic                        valid;
    logic                        ready;
    logic                        done_res;
    logic [cwpc_pkg::RESW-1:0]   status;

    modport source (output valid, done_res, status, input ready);
    modport sink   (input valid, done_res, status, output ready);
endinterface

`default_nettype wire

/* src/cwpc_datapath.sv */
// Datapath of the checker: configuration, support slots, graph stores,
// per-check work stores, walk queue and loop counters. Depends on cwpc_pkg.
`default_nettype none

module cwpc_datapath (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cwpc_pkg::dp_cmd_t         dcmd,
    input  wire logic                      cfg_we,
    input  wire logic                      cfg_index,
    input  wire logic [cwpc_pkg::CFG_DW-1:0] cfg_data,
    input  wire logic [cwpc_pkg::CMDW-1:0] ld_cmd,
    input  wire logic [cwpc_pkg::EW-1:0]   ld_edge_index,
    input  wire logic [cwpc_pkg::VW-1:0]   ld_end_a,
    input  wire logic [cwpc_pkg::VW-1:0]   ld_end_b,
    input  wire logic                      ld_in_cycle,
    input  wire logic [cwpc_pkg::SLW-1:0]  ld_support_slot,
    output cwpc_pkg::dp_stat_t             stat
);
    import cwpc_pkg::*;

    // Configuration and support slots
    logic [VCW-1:0] vcount_reg;
    logic [ECW-1:0] ecount_reg;
    logic [EW-1:0]  sup_reg [SUPPORT_SIZE];
    logic [VCW-1:0] nv;
    logic [ECW-1:0] ne;

    // Loop state
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [VW-1:0]  va_reg, vb_reg;
    logic           wbit_reg;
    logic [1:0]     dnew_reg, db_reg, xdeg_reg;
    logic [VW:0]    head_reg, tail_reg;
    logic           par_reg, k_reg;
    logic [VW-1:0]  n0_reg, n1_reg;

    // Stores
    logic [2*VW-1:0] ep_mem [MAX_EDGES];
    logic            wit_mem [MAX_EDGES];
    logic            term_mem [MAX_VERTICES];
    logic [1:0]      deg_mem [MAX_VERTICES];
    logic            vis_mem [MAX_VERTICES];
    logic [VW-1:0]   nb0_mem [MAX_VERTICES];
    logic [VW-1:0]   nb1_mem [MAX_VERTICES];
    logic [VW-1:0]   q_mem [MAX_VERTICES];

    logic [2*VW-1:0] ep_q;
    logic            wit_q, term_q0, term_q1, vis_q;
    logic [1:0]      deg_q0, deg_q1;
    logic [VW-1:0]   nb0_q, nb1_q, q_q;

    logic [EW-1:0]   ep_ra;
    logic [VW-1:0]   ta0, ta1, da0, da1, vra, nba, qra;
    logic            t_we, t_wd, d_we, v_we, v_wd, n0_we, n1_we, q_we;
    logic [VW-1:0]   t_wa, d_wa, v_wa, nw_a, nw_d, q_wa, q_wd;
    logic [1:0]      d_wd;

    logic [EW-1:0]   sup_sel;
    logic [VW-1:0]   ep_a, ep_b, cv, nsel;
    logic [1:0]      dsel;
    logic            ld_fire;

    assign nv      = (vcount_reg > VCW'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : vcount_reg;
    assign ne      = (ecount_reg > ECW'(MAX_EDGES)) ? ECW'(MAX_EDGES) : ecount_reg;
    assign sup_sel = sup_reg[cnt_reg[SLW-1:0]];
    assign ep_a    = ep_q[VW-1:0];
    assign ep_b    = ep_q[2*VW-1:VW];
    assign cv      = cnt_reg[VW-1:0];
    assign nsel    = k_reg ? n1_reg : n0_reg;
    assign dsel    = (va_reg == vb_reg) ? dnew_reg : db_reg;
    assign ld_fire = (dcmd.op == OP_LOAD);

    // Status, store addresses, write strobes and counter update per step
    always_comb
    begin
        stat     = '0;
        cnt_next = cnt_reg;
        ep_ra    = cnt_reg[EW-1:0];
        ta0 = cv;  ta1 = ep_b;
        da0 = cv;  da1 = ep_b;
        vra = cv;  nba = q_q;  qra = head_reg[VW-1:0];
        t_we = 1'b0; t_wa = cv; t_wd = 1'b0;
        d_we = 1'b0; d_wa = cv; d_wd = 2'd0;
        v_we = 1'b0; v_wa = cv; v_wd = 1'b0;
        n0_we = 1'b0; n1_we = 1'b0; nw_a = va_reg; nw_d = vb_reg;
        q_we = 1'b0; q_wa = tail_reg[VW-1:0]; q_wd = cv;
        unique case (dcmd.op)
            OP_START: cnt_next = '0;
            OP_CLR:
            begin
                t_we = 1'b1; d_we = 1'b1; v_we = 1'b1;
                stat.cnt_end = (cnt_reg == CW'(MAX_VERTICES - 1));
                cnt_next = stat.cnt_end ? '0 : cnt_reg + 1'b1;
            end
            OP_SUP_A:
            begin
                stat.sup_oor = ({1'b0, sup_sel} >= ne);
                ep_ra = sup_sel;
            end
            OP_SUP_B:
            begin
                ta0 = ep_a; ta1 = ep_b;
            end
            OP_SUP_C:
            begin
                stat.term_hit = term_q0 | term_q1;
                t_we = ~stat.term_hit; t_wa = va_reg; t_wd = 1'b1;
            end
            OP_SUP_D:
            begin
                t_we = 1'b1; t_wa = vb_reg; t_wd = 1'b1;
                stat.wit_sel = wbit_reg;
                stat.cnt_end = (cnt_reg == CW'(SUPPORT_SIZE - 1));
                cnt_next = stat.cnt_end ? '0 : cnt_reg + 1'b1;
            end
            OP_EDG_A:
            begin
                stat.cnt_end = (cnt_reg >= CW'(ne));
                if (stat.cnt_end)
                begin
                    cnt_next = '0;
                end
            end
            OP_EDG_B:
            begin
                da0 = ep_a; da1 = ep_b;
                stat.edge_sel = wit_q;
                stat.edge_oob = ({1'b0, ep_a} >= nv) || ({1'b0, ep_b} >= nv);
                if (!wit_q)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_EDG_C:
            begin
                // First endpoint takes the second as neighbor
                d_we = 1'b1; d_wa = va_reg; d_wd = sat_inc(deg_q0);
                n0_we = (deg_q0 == 2'd0); n1_we = (deg_q0 == 2'd1);
                nw_a = va_reg; nw_d = vb_reg;
            end
            OP_EDG_D:
            begin
                // Second endpoint; a self-loop sees the count just written
                d_we = 1'b1; d_wa = vb_reg; d_wd = sat_inc(dsel);
                n0_we = (dsel == 2'd0); n1_we = (dsel == 2'd1);
                nw_a = vb_reg; nw_d = va_reg;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_DEG_A:
            begin
                stat.cnt_end = (cnt_reg >= CW'(nv));
                if (stat.cnt_end)
                begin
                    cnt_next = '0;
                end
            end
            OP_DEG_B:
            begin
                stat.deg_bad = term_q0 ? (deg_q0 != 2'd2) : deg_q0[0];
                cnt_next = cnt_reg + 1'b1;
            end
            OP_WLK_A: stat.cnt_end = (cnt_reg >= CW'(nv));
            OP_WLK_B:
            begin
                stat.skip = (deg_q0 == 2'd0) || vis_q;
                if (stat.skip)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else
                begin
                    v_we = 1'b1; v_wd = 1'b1;
                    q_we = 1'b1; q_wa = '0; q_wd = cv;
                end
            end
            OP_Q_A:
            begin
                stat.q_empty = (head_reg == tail_reg);
                stat.parity  = par_reg;
                if (stat.q_empty)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            OP_Q_B:
            begin
                ta0 = q_q; da0 = q_q; nba = q_q;
            end
            OP_Q_C: stat.has_nb = (deg_q0 != 2'd0);
            OP_N_RD: vra = nsel;
            OP_N_CHK:
            begin
                v_we = ~vis_q; v_wa = nsel; v_wd = 1'b1;
                q_we = ~vis_q & ~tail_reg[VW]; q_wd = nsel;
                stat.more_nb = ~k_reg & xdeg_reg[1];
            end
            default: ;
        endcase
    end

    // Hold configuration, support slots and the loop counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg <= VCW'(MAX_VERTICES);
            ecount_reg <= ECW'(MAX_EDGES);
            cnt_reg    <= '0;
            for (int i = 0; i < SUPPORT_SIZE; i++)
            begin
                sup_reg[i] <= '0;
            end
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_VERTEX_COUNT: vcount_reg <= cfg_data[VCW-1:0];
                    CFG_EDGE_COUNT:   ecount_reg <= cfg_data[ECW-1:0];
                    default: ;
                endcase
            end
            if (ld_fire && ld_cmd == CMD_SUP)
            begin
                sup_reg[ld_support_slot] <= ld_edge_index;
            end
        end
    end

    // Advance the working registers of each step
    always_ff @(posedge clk)
    begin
        unique case (dcmd.op)
            OP_SUP_B:
            begin
                va_reg <= ep_a; vb_reg <= ep_b; wbit_reg <= wit_q;
            end
            OP_EDG_B:
            begin
                va_reg <= ep_a; vb_reg <= ep_b;
            end
            OP_EDG_C:
            begin
                dnew_reg <= sat_inc(deg_q0); db_reg <= deg_q1;
            end
            OP_WLK_B:
            begin
                head_reg <= '0; tail_reg <= (VW+1)'(1); par_reg <= 1'b0;
            end
            OP_Q_A:
            begin
                if (head_reg != tail_reg)
                begin
                    head_reg <= head_reg + 1'b1;
                end
            end
            OP_Q_B: k_reg <= 1'b0;
            OP_Q_C:
            begin
                par_reg <= par_reg ^ term_q0; xdeg_reg <= deg_q0;
                n0_reg <= nb0_q; n1_reg <= nb1_q;
            end
            OP_N_CHK:
            begin
                k_reg <= 1'b1;
                if (q_we)
                begin
                    tail_reg <= tail_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Graph stores: loaded by commands, read during a check
    always_ff @(posedge clk)
    begin
        if (ld_fire && ld_cmd == CMD_EDGE)
        begin
            ep_mem[ld_edge_index] <= {ld_end_b, ld_end_a};
        end
        if (ld_fire && ld_cmd == CMD_WIT)
        begin
            wit_mem[ld_edge_index] <= ld_in_cycle;
        end
        ep_q  <= ep_mem[ep_ra];
        wit_q <= wit_mem[ep_ra];
    end

    // Terminal marks: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            term_mem[t_wa] <= t_wd;
        end
        term_q0 <= term_mem[ta0];
        term_q1 <= term_mem[ta1];
    end

    // Degree counters: one write port, two read ports
    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            deg_mem[d_wa] <= d_wd;
        end
        deg_q0 <= deg_mem[da0];
        deg_q1 <= deg_mem[da1];
    end

    // Visited marks
    always_ff @(posedge clk)
    begin
        if (v_we)
        begin
            vis_mem[v_wa] <= v_wd;
        end
        vis_q <= vis_mem[vra];
    end

    // Neighbor pairs, one store per slot
    always_ff @(posedge clk)
    begin
        if (n0_we)
        begin
            nb0_mem[nw_a] <= nw_d;
        end
        if (n1_we)
        begin
            nb1_mem[nw_a] <= nw_d;
        end
        nb0_q <= nb0_mem[nba];
        nb1_q <= nb1_mem[nba];
    end

    // Walk queue
    always_ff @(posedge clk)
    begin
        if (q_we)
        begin
            q_mem[q_wa] <= q_wd;
        end
        q_q <= q_mem[qra];
    end

endmodule

`default_nettype wire

/* src/cwpc_ctrl.sv */
// Controller of the checker: sequences the check steps and picks the status.
// Depends on cwpc_pkg.
`default_nettype none

module cwpc_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_fire,
    input  wire logic [cwpc_pkg::CMDW-1:0] in_cmd,
    input  wire logic                      out_free,
    input  wire cwpc_pkg::dp_stat_t        stat,
    output cwpc_pkg::dp_cmd_t              dcmd,
    output logic                           idle,
    output logic                           res_load,
    output logic [cwpc_pkg::RESW-1:0]      res_status
);
    import cwpc_pkg::*;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    assign idle       = (state_reg == S_IDLE);
    assign res_status = res_reg;

    // Hold state and pending status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Next state and step command
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        dcmd.op    = OP_NONE;
        res_load   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && in_cmd == CMD_CHECK)
                begin
                    dcmd.op = OP_START; state_next = S_CLR;
                end
                else if (in_fire)
                begin
                    dcmd.op = OP_LOAD;
                end
            end
            S_CLR:
            begin
                dcmd.op = OP_CLR;
                if (stat.cnt_end) state_next = S_SUP_A;
            end
            S_SUP_A:
            begin
                dcmd.op = OP_SUP_A;
                if (stat.sup_oor)
                begin
                    res_next = RES_SUP_RANGE; state_next = S_FIN;
                end
                else state_next = S_SUP_B;
            end
            S_SUP_B:
            begin
                dcmd.op = OP_SUP_B; state_next = S_SUP_C;
            end
            S_SUP_C:
            begin
                dcmd.op = OP_SUP_C;
                if (stat.term_hit)
                begin
                    res_next = RES_SUP_MATCH; state_next = S_FIN;
                end
                else state_next = S_SUP_D;
            end
            S_SUP_D:
            begin
                dcmd.op = OP_SUP_D;
                if (stat.wit_sel)
                begin
                    res_next = RES_WIT_SUP; state_next = S_FIN;
                end
                else if (stat.cnt_end) state_next = S_EDG_A;
                else state_next = S_SUP_A;
            end
            S_EDG_A:
            begin
                dcmd.op = OP_EDG_A;
                state_next = stat.cnt_end ? S_DEG_A : S_EDG_B;
            end
            S_EDG_B:
            begin
                dcmd.op = OP_EDG_B;
                if (!stat.edge_sel) state_next = S_EDG_A;
                else if (stat.edge_oob)
                begin
                    res_next = RES_BAD_DEG; state_next = S_FIN;
                end
                else state_next = S_EDG_C;
            end
            S_EDG_C:
            begin
                dcmd.op = OP_EDG_C; state_next = S_EDG_D;
            end
            S_EDG_D:
            begin
                dcmd.op = OP_EDG_D; state_next = S_EDG_A;
            end
            S_DEG_A:
            begin
                dcmd.op = OP_DEG_A;
                state_next = stat.cnt_end ? S_WLK_A : S_DEG_B;
            end
            S_DEG_B:
            begin
                dcmd.op = OP_DEG_B;
                if (stat.deg_bad)
                begin
                    res_next = RES_BAD_DEG; state_next = S_FIN;
                end
                else state_next = S_DEG_A;
            end
            S_WLK_A:
            begin
                dcmd.op = OP_WLK_A;
                if (stat.cnt_end)
                begin
                    res_next = RES_OK; state_next = S_FIN;
                end
                else state_next = S_WLK_B;
            end
            S_WLK_B:
            begin
                dcmd.op = OP_WLK_B;
                state_next = stat.skip ? S_WLK_A : S_Q_A;
            end
            S_Q_A:
            begin
                dcmd.op = OP_Q_A;
                if (stat.q_empty && stat.parity)
                begin
                    res_next = RES_ODD_COMP; state_next = S_FIN;
                end
                else if (stat.q_empty) state_next = S_WLK_A;
                else state_next = S_Q_B;
            end
            S_Q_B:
            begin
                dcmd.op = OP_Q_B; state_next = S_Q_C;
            end
            S_Q_C:
            begin
                dcmd.op = OP_Q_C;
                state_next = stat.has_nb ? S_N_RD : S_Q_A;
            end
            S_N_RD:
            begin
                dcmd.op = OP_N_RD; state_next = S_N_CHK;
            end
            S_N_CHK:
            begin
                dcmd.op = OP_N_CHK;
                state_next = stat.more_nb ? S_N_RD : S_Q_A;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    res_load = 1'b1; state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

/* src/cycle_witness_parity_checker_unit.sv */
// Load commands give their result (done_res 0) from an output register, so
// loads stream at one per cycle while results are taken.
// A check runs as a sequence of steps over the stores: it clears the per-check
// marks, checks each support slot, walks every edge and links the selected ones,
// tests the degree of each vertex, then walks each component through a queue,
// visiting each queued vertex and its neighbors; the final status goes to the
// output register. No item is accepted while a check runs.
// Depends on cwpc_pkg, cwpc_item_if, cwpc_ctrl and cwpc_datapath.
`default_nettype none

module cycle_witness_parity_checker_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    cwpc_item_if.sink                        item,
    cwpc_result_if.source                    result,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_index,
    input  wire logic [cwpc_pkg::CFG_DW-1:0] cfg_data
);
    import cwpc_pkg::*;

    dp_cmd_t         dcmd;
    dp_stat_t        stat;
    logic            ctrl_idle, res_load, out_free, in_fire;
    logic [RESW-1:0] res_status;
    logic            rvalid_reg, rdone_reg;
    logic [RESW-1:0] rstatus_reg;

    assign out_free   = ~rvalid_reg | result.ready;
    assign item.ready = ctrl_idle & out_free;
    assign in_fire    = item.valid & item.ready;

    assign result.valid    = rvalid_reg;
    assign result.done_res = rdone_reg;
    assign result.status   = rstatus_reg;

    cwpc_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_fire    (in_fire),
        .in_cmd     (item.cmd),
        .out_free   (out_free),
        .stat       (stat),
        .dcmd       (dcmd),
        .idle       (ctrl_idle),
        .res_load   (res_load),
        .res_status (res_status)
    );

    cwpc_datapath u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .dcmd            (dcmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .ld_cmd          (item.cmd),
        .ld_edge_index   (item.edge_index),
        .ld_end_a        (item.end_a),
        .ld_end_b        (item.end_b),
        .ld_in_cycle     (item.in_cycle),
        .ld_support_slot (item.support_slot),
        .stat            (stat)
    );

    // Result register: load results at once, check results when done
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else if ((in_fire && item.cmd != CMD_CHECK) || res_load)
        begin
            rvalid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            rvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && item.cmd != CMD_CHECK)
        begin
            rdone_reg   <= 1'b0;
            rstatus_reg <= RES_OK;
        end
        else if (res_load)
        begin
            rdone_reg   <= 1'b1;
            rstatus_reg <= res_status;
        end
    end

`ifndef SYNTH
    a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && item.cmd != CMD_CHECK) |=> (result.valid && !result.done_res))
        else $error("load transfer did not produce a load result");

    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl_idle |-> !item.ready)
        else $error("input accepted while a check runs");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> (res_status <= RES_ODD_COMP))
        else $error("check finished with an unknown status");
`endif

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for cycle_witness_parity_checker_unit: directed table, then random graph jobs.
// Depends on cwpc_pkg and the cwpc_item_if / cwpc_result_if channel interfaces.
`timescale 1ns / 100ps

module tb;
    import cwpc_pkg::*;

    typedef struct packed {
        logic done;
        res_t st;
    } outcome_t;

    typedef struct {
        cmd_t       c;
        logic [10:0] idx;
        logic [9:0] a;
        logic [9:0] b;
        logic       sel;
        logic [1:0] slot;
        logic       typed;
        res_t       want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [CFG_DW-1:0] cfg_data;

    cwpc_item_if   in_if();
    cwpc_result_if out_if();

    cycle_witness_parity_checker_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (in_if),
        .result    (out_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Mirror of the graph, witness and support stores
    logic [9:0]  g_end_a [0:MAX_EDGES-1];
    logic [9:0]  g_end_b [0:MAX_EDGES-1];
    logic        g_sel   [0:MAX_EDGES-1];
    logic [10:0] g_sup   [0:SUPPORT_SIZE-1];
    int unsigned g_vcount;
    int unsigned g_ecount;

    // Per-check working stores
    logic        w_term [0:MAX_VERTICES-1];
    logic [1:0]  w_deg  [0:MAX_VERTICES-1];
    logic [9:0]  w_nb0  [0:MAX_VERTICES-1];
    logic [9:0]  w_nb1  [0:MAX_VERTICES-1];
    logic        w_vis  [0:MAX_VERTICES-1];
    int          w_walk [0:MAX_VERTICES-1];

    outcome_t pending_q[$];
    stim_row_t dir_rows[$];
    int errors;
    int transfers;
    int checks_done;
    int status_seen [0:7];
    logic burst;
    logic hold_rx;

    function automatic void link_vertex(logic [9:0] v, logic [9:0] n);
        if (w_deg[v] == 2'd0)
            w_nb0[v] = n;
        else if (w_deg[v] == 2'd1)
            w_nb1[v] = n;
        if (w_deg[v] != 2'd3)
            w_deg[v] = w_deg[v] + 2'd1;
    endfunction

    // Compute the status of a check from the mirrored stores
    function automatic res_t check_witness();
        int nv;
        int ne;
        int s;
        int e;
        int v;
        int k;
        int x;
        int head;
        int tail;
        int cnt;
        logic [9:0] a;
        logic [9:0] b;
        logic [9:0] n;
        logic [10:0] se;
        nv = (g_vcount > MAX_VERTICES) ? MAX_VERTICES : g_vcount;
        ne = (g_ecount > MAX_EDGES) ? MAX_EDGES : g_ecount;
        for (v = 0; v < MAX_VERTICES; v++)
        begin
            w_term[v] = 1'b0;
            w_deg[v]  = 2'd0;
            w_vis[v]  = 1'b0;
        end
        // Support edges: range, shared endpoints, selected by the witness
        for (s = 0; s < SUPPORT_SIZE; s++)
        begin
            se = g_sup[s];
            if (se >= ne)
                return RES_SUP_RANGE;
            a = g_end_a[se];
            b = g_end_b[se];
            if (w_term[a] || w_term[b])
                return RES_SUP_MATCH;
            w_term[a] = 1'b1;
            w_term[b] = 1'b1;
            if (g_sel[se])
                return RES_WIT_SUP;
        end
        // Accumulate degree of selected edges
        for (e = 0; e < ne; e++)
        begin
            if (!g_sel[e])
                continue;
            a = g_end_a[e];
            b = g_end_b[e];
            if (a >= nv || b >= nv)
                return RES_BAD_DEG;
            link_vertex(a, b);
            link_vertex(b, a);
        end
        for (v = 0; v < nv; v++)
        begin
            if (w_term[v] ? (w_deg[v] != 2'd2) : !(w_deg[v] == 2'd0 || w_deg[v] == 2'd2))
                return RES_BAD_DEG;
        end
        // Walk each component and count its terminals
        for (v = 0; v < nv; v++)
        begin
            if (w_deg[v] == 2'd0 || w_vis[v])
                continue;
            w_vis[v] = 1'b1;
            head = 0;
            tail = 0;
            cnt = 0;
            w_walk[tail] = v;
            tail++;
            while (head < tail)
            begin
                x = w_walk[head];
                head++;
                cnt += int'(w_term[x]);
                for (k = 0; k < 2 && k < w_deg[x]; k++)
                begin
                    n = (k == 0) ? w_nb0[x] : w_nb1[x];
                    if (w_vis[n])
                        continue;
                    w_vis[n] = 1'b1;
                    if (tail < MAX_VERTICES)
                    begin
                        w_walk[tail] = n;
                        tail++;
                    end
                end
            end
            if (cnt[0])
                return RES_ODD_COMP;
        end
        return RES_OK;
    endfunction

    // Apply an accepted transfer to the mirror and queue its outcome
    task automatic record_item(input stim_row_t r);
        outcome_t o;
        o.done = 1'b0;
        o.st = RES_OK;
        case (r.c)
            CMD_EDGE:
            begin
                g_end_a[r.idx] = r.a;
                g_end_b[r.idx] = r.b;
            end
            CMD_WIT:
                g_sel[r.idx] = r.sel;
            CMD_SUP:
                g_sup[r.slot] = r.idx;
            default:
            begin
                o.done = 1'b1;
                o.st = check_witness();
                checks_done++;
            end
        endcase
        if (r.typed)
            o.st = r.want;
        pending_q = {pending_q, o};
        transfers++;
    endtask

    // Drive one item and hold it until the block takes it
    task automatic send_item(input stim_row_t r);
        int gap;
        int pick;
        @(negedge clk);
        pick = $urandom_range(0, 99);
        gap = burst ? 0 : (pick < 55) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                         : $urandom_range(10, 40);
        if (gap > 0)
        begin
            in_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.cmd = r.c;
        in_if.edge_index = r.idx;
        in_if.end_a = r.a;
        in_if.end_b = r.b;
        in_if.in_cycle = r.sel;
        in_if.support_slot = r.slot;
        in_if.valid = 1'b1;
        do
            @(posedge clk);
        while (!in_if.ready);
        record_item(r);
    endtask

    task automatic put(input cmd_t c, input int idx, input int a, input int b,
                       input logic sel, input int slot);
        stim_row_t r;
        r.c = c;
        r.idx = 11'(idx);
        r.a = 10'(a);
        r.b = 10'(b);
        r.sel = sel;
        r.slot = 2'(slot);
        r.typed = 1'b0;
        r.want = RES_OK;
        send_item(r);
    endtask

    function automatic void add_row(input cmd_t c, input int idx, input int a, input int b,
                                    input logic sel, input int slot, input logic typed,
                                    input res_t want);
        stim_row_t r;
        r.c = c;
        r.idx = 11'(idx);
        r.a = 10'(a);
        r.b = 10'(b);
        r.sel = sel;
        r.slot = 2'(slot);
        r.typed = typed;
        r.want = want;
        dir_rows = {dir_rows, r};
    endfunction

    // Drop valid and wait until every outstanding result has come back
    task automatic drain();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t i, input int unsigned d);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = i;
        cfg_data = CFG_DW'(d);
        @(negedge clk);
        cfg_we = 1'b0;
        if (i == CFG_VERTEX_COUNT)
            g_vcount = d & 32'h7FF;
        else
            g_ecount = d & 32'hFFF;
    endtask

    // One random job: two selected cycles, four disjoint support edges, then checks
    task automatic run_job();
        int l1;
        int l2;
        int nv;
        int ne;
        int i;
        int j;
        int t;
        int nck;
        int nmut;
        int m;
        int perm[0:63];
        int cyc[0:15];
        int a;
        int b;
        logic sel;
        l1 = $urandom_range(3, 8);
        l2 = (l1 >= 5) ? $urandom_range(3, 8) : $urandom_range(8 - l1, 8);
        nv = $urandom_range(l1 + l2, l1 + l2 + 12);
        ne = l1 + l2 + 4 + $urandom_range(0, 8);
        burst = ($urandom_range(0, 3) == 0);
        drain();
        write_reg(CFG_VERTEX_COUNT, nv);
        write_reg(CFG_EDGE_COUNT, ne);
        for (i = 0; i < nv; i++)
            perm[i] = i;
        for (i = nv - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i < l1 + l2; i++)
            cyc[i] = perm[i];
        for (i = l1 + l2 - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            t = cyc[i];
            cyc[i] = cyc[j];
            cyc[j] = t;
        end
        for (i = 0; i < ne; i++)
        begin
            sel = 1'b0;
            if (i < l1)
            begin
                a = perm[i];
                b = perm[(i + 1) % l1];
                sel = 1'b1;
            end
            else if (i < l1 + l2)
            begin
                a = perm[i];
                b = perm[l1 + (i - l1 + 1) % l2];
                sel = 1'b1;
            end
            else if (i < l1 + l2 + 4)
            begin
                a = cyc[2 * (i - l1 - l2)];
                b = cyc[2 * (i - l1 - l2) + 1];
            end
            else
            begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, nv - 1);
            end
            put(CMD_EDGE, i, a, b, 1'b0, 0);
            put(CMD_WIT, i, $urandom_range(0, 1023), 0, sel, $urandom_range(0, 3));
        end
        for (i = 0; i < SUPPORT_SIZE; i++)
            put(CMD_SUP, l1 + l2 + i, $urandom_range(0, 1023), $urandom_range(0, 1023),
                1'($urandom_range(0, 1)), i);
        nck = $urandom_range(1, 3);
        for (i = 0; i < nck; i++)
        begin
            nmut = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
            for (m = 0; m < nmut; m++)
            begin
                case ($urandom_range(0, 5))
                    0: put(CMD_WIT, $urandom_range(0, ne - 1), 0, 0,
                           1'($urandom_range(0, 1)), 0);
                    1: put(CMD_SUP, $urandom_range(0, ne + 2), 0, 0, 1'b0, $urandom_range(0, 3));
                    2: put(CMD_SUP, $urandom_range(0, 2047), 0, 0, 1'b0, $urandom_range(0, 3));
                    3:
                    begin
                        a = $urandom_range(0, nv - 1);
                        b = $urandom_range(0, 1) ? a : $urandom_range(0, nv - 1);
                        put(CMD_EDGE, $urandom_range(0, ne - 1), a, b, 1'b0, 0);
                    end
                    4: put(CMD_EDGE, $urandom_range(0, 2047), $urandom_range(0, 1023),
                           $urandom_range(0, 1023), 1'b0, 0);
                    default:
                    begin
                        drain();
                        t = $urandom_range(0, 3);
                        write_reg(CFG_VERTEX_COUNT, (t == 0) ? 0 : (t == 1) ? 1 :
                                  (t == 2) ? 2047 : nv - 1);
                        if ($urandom_range(0, 3) == 0)
                            write_reg(CFG_EDGE_COUNT, $urandom_range(0, 1));
                    end
                endcase
            end
            put(CMD_CHECK, $urandom_range(0, 2047), $urandom_range(0, 1023),
                $urandom_range(0, 1023), 1'($urandom_range(0, 1)), $urandom_range(0, 3));
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard limit on run time
    initial
    begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Long receiver hold-off once traffic is flowing, counted here
    initial
    begin
        hold_rx = 1'b0;
        wait (transfers >= 200);
        @(negedge clk);
        hold_rx = 1'b1;
        repeat (300) @(posedge clk);
        hold_rx = 1'b0;
    end

    // Result side: random ready with short and long stalls
    initial
    begin
        int pick;
        int stall;
        out_if.ready = 1'b0;
        stall = 0;
        forever
        begin
            @(negedge clk);
            if (hold_rx)
                out_if.ready = 1'b0;
            else if (stall > 0)
            begin
                out_if.ready = 1'b0;
                stall--;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (burst || pick < 60)
                    out_if.ready = 1'b1;
                else
                begin
                    out_if.ready = 1'b0;
                    stall = (pick < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                end
            end
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin
        outcome_t o;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("unexpected result: done_res=%0d status=%0d",
                       out_if.done_res, out_if.status);
                errors++;
            end
            else
            begin
                o = pending_q.pop_front();
                if (out_if.done_res !== o.done)
                begin
                    $error("done_res: expected %0d, got %0d", o.done, out_if.done_res);
                    errors++;
                end
                if (out_if.status !== o.st)
                begin
                    $error("status: expected %0d, got %0d", o.st, out_if.status);
                    errors++;
                end
                if (o.done)
                    status_seen[o.st]++;
            end
        end
    end

    // Stimulus sequence
    initial
    begin
        int i;
        errors = 0;
        transfers = 0;
        checks_done = 0;
        burst = 1'b0;
        for (i = 0; i < 8; i++)
            status_seen[i] = 0;
        for (i = 0; i < SUPPORT_SIZE; i++)
            g_sup[i] = '0;
        g_vcount = MAX_VERTICES;
        g_ecount = MAX_EDGES;
        in_if.valid = 1'b0;
        in_if.cmd = CMD_EDGE;
        in_if.edge_index = '0;
        in_if.end_a = '0;
        in_if.end_b = '0;
        in_if.in_cycle = 1'b0;
        in_if.support_slot = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_VERTEX_COUNT;
        cfg_data = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: field extremes, every command, each early failure
        write_reg(CFG_VERTEX_COUNT, 8);
        write_reg(CFG_EDGE_COUNT, 4);
        add_row(CMD_EDGE, 0, 0, 1, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_EDGE, 1, 1, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_EDGE, 2, 2, 3, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_EDGE, 3, 1023, 1023, 1'b1, 3, 1'b1, RES_OK);
        add_row(CMD_EDGE, 2047, 1023, 1023, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_WIT, 0, 0, 0, 1'b1, 0, 1'b1, RES_OK);
        add_row(CMD_WIT, 1, 0, 0, 1'b1, 0, 1'b1, RES_OK);
        add_row(CMD_WIT, 2, 0, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_WIT, 3, 0, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_WIT, 2047, 1023, 1023, 1'b1, 3, 1'b1, RES_OK);
        add_row(CMD_SUP, 2047, 0, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_CHECK, 0, 0, 0, 1'b0, 0, 1'b1, RES_SUP_RANGE);
        add_row(CMD_SUP, 0, 0, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_CHECK, 2047, 1023, 1023, 1'b1, 3, 1'b1, RES_WIT_SUP);
        add_row(CMD_SUP, 2, 0, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_SUP, 2, 0, 0, 1'b0, 1, 1'b1, RES_OK);
        add_row(CMD_CHECK, 0, 0, 0, 1'b0, 0, 1'b1, RES_SUP_MATCH);
        add_row(CMD_WIT, 0, 0, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_SUP, 3, 0, 0, 1'b0, 1, 1'b1, RES_OK);
        add_row(CMD_SUP, 0, 0, 0, 1'b0, 2, 1'b1, RES_OK);
        add_row(CMD_SUP, 1, 0, 0, 1'b0, 3, 1'b1, RES_OK);
        add_row(CMD_CHECK, 0, 0, 0, 1'b0, 0, 1'b0, RES_OK);
        add_row(CMD_WIT, 1, 0, 0, 1'b0, 0, 1'b1, RES_OK);
        add_row(CMD_CHECK, 0, 0, 0, 1'b0, 0, 1'b0, RES_OK);
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // Random graph jobs
        while (transfers < 890)
            run_job();

        // Full vertex range: cycle on the top vertices, clamped vertex count
        burst = 1'b1;
        drain();
        write_reg(CFG_VERTEX_COUNT, 2047);
        write_reg(CFG_EDGE_COUNT, 64);
        for (i = 0; i < 64; i++)
        begin
            put(CMD_EDGE, i, $urandom_range(0, 1023), $urandom_range(0, 1023), 1'b0, 0);
            put(CMD_WIT, i, 0, 0, 1'b0, 0);
        end
        for (i = 0; i < 8; i++)
        begin
            put(CMD_EDGE, 40 + i, 1016 + i, 1016 + (i + 1) % 8, 1'b0, 0);
            put(CMD_WIT, 40 + i, 0, 0, 1'b1, 0);
        end
        for (i = 0; i < SUPPORT_SIZE; i++)
        begin
            put(CMD_EDGE, 30 + i, 1016 + 2 * i, 1017 + 2 * i, 1'b0, 0);
            put(CMD_SUP, 30 + i, 0, 0, 1'b0, i);
        end
        put(CMD_CHECK, 0, 0, 0, 1'b0, 0);
        burst = 1'b0;
        drain();
        write_reg(CFG_VERTEX_COUNT, 1024);
        put(CMD_CHECK, 0, 0, 0, 1'b0, 0);
        drain();
        write_reg(CFG_VERTEX_COUNT, 1023);
        put(CMD_CHECK, 0, 0, 0, 1'b0, 0);
        drain();

        // Clamped edge count, stopped by a selected support edge
        write_reg(CFG_VERTEX_COUNT, 1024);
        write_reg(CFG_EDGE_COUNT, 4095);
        put(CMD_SUP, 40, 0, 0, 1'b0, 0);
        put(CMD_CHECK, 0, 0, 0, 1'b0, 0);
        drain();
        write_reg(CFG_VERTEX_COUNT, 1);
        write_reg(CFG_EDGE_COUNT, 0);
        put(CMD_CHECK, 0, 0, 0, 1'b0, 0);

        drain();
        repeat (50) @(posedge clk);
        $display("Covered %0d transfers and %0d checks over several graph sizes.",
                 transfers, checks_done);
        $display("Check outcomes ok/range/match/witness/degree/odd: %0d %0d %0d %0d %0d %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (errors == 0 && pending_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
